### design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP cache
// Entry count, request codes, register indexes, controller states and cell bus types.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int ENTRIES  = 8;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_LEARN    = 2'd1;
    localparam logic [1:0] REQ_LOOKUP   = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [1:0] REG_SUBNET_MASK = 2'd1;
    localparam logic [1:0] REG_ROUTER_IP   = 2'd2;
    localparam logic [1:0] REG_MAX_AGE     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic        tick;      // advance-age check this cycle
        logic        wr;        // write learn data into selected cell
        logic [IDX_W-1:0] wr_idx;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [7:0]  now;
        logic [7:0]  max_age;
    } cell_cmd_t;

    // Entry view handed along the chain, one cell per cycle while the chain rotates.
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [7:0]  stamp;
    } entry_t;

endpackage

### design/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell: one cache entry
// Holds one entry, takes a learn write when selected, ages it out on tick and
// loads its neighbor's entry when the chain rotates.
// ----------------------------------------------------------------------------
module arpc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  arpc_pkg::cell_cmd_t   cmd,
    input  logic                  rot,
    input  logic [arpc_pkg::IDX_W-1:0] my_idx,
    input  arpc_pkg::entry_t      prev,
    output arpc_pkg::entry_t      cur
);
    import arpc_pkg::*;

    entry_t e_reg, e_next;
    logic [7:0] age;

    assign age = cmd.now - e_reg.stamp;
    assign cur = e_reg;

    always_comb
    begin
        e_next = e_reg;
        if (rot)
        begin
            e_next = prev;
        end
        else if (cmd.wr && cmd.wr_idx == my_idx)
        begin
            e_next.ip    = cmd.ip;
            e_next.mac   = cmd.mac;
            e_next.stamp = cmd.now;
        end
        else if (cmd.tick && e_reg.ip != 32'd0 && age >= cmd.max_age)
        begin
            e_next.ip = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_reg <= '0;
        else
            e_reg <= e_next;
    end

endmodule

### design/arp_cache_with_aging_unit.sv
// ----------------------------------------------------------------------------
// arp_cache_with_aging_unit: IPv4-to-MAC cache with tick-based aging
// Chain of entry cells rotated past one scan point by a small controller.
// ----------------------------------------------------------------------------
// Usage: send items on s_axis; tdata holds req_type (0 tick, 1 learn,
// 2 lookup), target_ip and mac_addr. A tick does not close the input:
// the clock advances at acceptance and every cell ages out its own entry in
// parallel on the next cycle, while the input stays open. Learn
// and lookup rotate the ring of ENTRIES cells once past the scan point at
// cell 0, one entry per cycle; the ring ends back in its original order. A
// learn scans and then writes in the write state before the input reopens.
// A lookup result is registered after the scan and the output state, and
// the input reopens the cycle after the result item is taken. A broadcast
// lookup skips the scan and its result is valid the cycle after acceptance.
// Ignored items (learn of IP 0, request type 3) leave the input open. Only
// lookups produce a result item on m_axis. One item is worked on at a time.
// Write the configuration registers only while idle.
module arp_cache_with_aging_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [87:0]   s_axis_tdata,   // req_type[1:0], target_ip[33:2], mac_addr[81:34]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [87:0]   m_axis_tdata,   // found[0], dest_mac[48:1], is_broadcast[49], request_ip[81:50]
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata
);
    import arpc_pkg::*;

    logic [31:0] local_ip_reg, mask_reg, router_reg;
    logic [7:0]  max_age_reg, now_reg, now_next;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]  req_reg;
    logic [31:0] ip_reg;    // learn ip, or lookup next hop
    logic [47:0] mac_reg;

    // scan results
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [47:0]      hit_mac_reg, hit_mac_next;
    logic             free_ok_reg, free_ok_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] old_idx_reg, old_idx_next;
    logic [7:0]       old_age_reg, old_age_next;
    logic             old_ok_reg, old_ok_next;

    logic        ov_reg;
    logic [87:0] od_reg;
    logic        bcast_hold_reg;

    cell_cmd_t cmd;
    logic      rot;
    entry_t    ring [ENTRIES];
    entry_t    head;
    logic [7:0] head_age;
    logic [IDX_W-1:0] scan_idx;

    logic accept;
    logic [1:0]  in_req;
    logic [31:0] in_ip;
    logic [47:0] in_mac;
    logic        in_bcast;
    logic [31:0] in_hop;

    assign in_req = s_axis_tdata[1:0];
    assign in_ip  = s_axis_tdata[33:2];
    assign in_mac = s_axis_tdata[81:34];

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign in_bcast = (in_ip == 32'hFFFF_FFFF) || (in_ip == (local_ip_reg | ~mask_reg));
    assign in_hop = ((in_ip & mask_reg) != (local_ip_reg & mask_reg)) ? router_reg : in_ip;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= 32'd0;
            mask_reg     <= 32'hFFFF_FF00;
            router_reg   <= 32'd0;
            max_age_reg  <= 8'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LOCAL_IP:    local_ip_reg <= cfg_wdata;
                REG_SUBNET_MASK: mask_reg     <= cfg_wdata;
                REG_ROUTER_IP:   router_reg   <= cfg_wdata;
                REG_MAX_AGE:     max_age_reg  <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    // cell chain: cell k loads from cell k+1 on rotate, so the scan point at
    // cell 0 sees entries in index order
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            arpc_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (cmd),
                .rot    (rot),
                .my_idx (IDX_W'(g)),
                .prev   (ring[(g + 1) % ENTRIES]),
                .cur    (ring[g])
            );
        end
    endgenerate

    assign head     = ring[0];
    assign head_age = now_reg - head.stamp;
    assign scan_idx = cnt_reg[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && (in_req == REQ_LEARN || in_req == REQ_LOOKUP) &&
                    !(in_req == REQ_LEARN && in_ip == 32'd0) &&
                    !(in_req == REQ_LOOKUP && in_bcast))
                    state_next = ST_SCAN;
            ST_SCAN:
                if (cnt_reg == CNT_W'(ENTRIES - 1))
                    state_next = (req_reg == REQ_LEARN) ? ST_WRITE : ST_OUT;
            ST_WRITE: state_next = ST_IDLE;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs / datapath control
    always_comb
    begin
        rot          = (state_reg == ST_SCAN);
        cnt_next     = (state_reg == ST_SCAN) ? cnt_reg + 1'b1 : '0;
        now_next     = now_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_mac_next = hit_mac_reg;
        free_ok_next = free_ok_reg;
        free_idx_next = free_idx_reg;
        old_idx_next = old_idx_reg;
        old_age_next = old_age_reg;
        old_ok_next  = old_ok_reg;
        cmd.tick     = 1'b0;
        cmd.wr       = 1'b0;
        cmd.wr_idx   = '0;
        cmd.ip       = ip_reg;
        cmd.mac      = mac_reg;
        cmd.now      = now_reg;
        cmd.max_age  = max_age_reg;

        if (state_reg == ST_IDLE)
        begin
            hit_next = 1'b0; free_ok_next = 1'b0; old_ok_next = 1'b0;
            old_age_next = '0;
            if (accept && in_req == REQ_TICK)
                now_next = now_reg + 8'd1;
        end
        // aging check runs the cycle after the clock advanced
        if (state_reg == ST_IDLE && req_reg == REQ_TICK && bcast_hold_reg)
            cmd.tick = 1'b1;

        if (state_reg == ST_SCAN && head.ip != 32'd0)
        begin
            if (head.ip == ip_reg)
            begin
                // lookup keeps lowest hit, learn keeps highest
                if (!hit_reg || req_reg == REQ_LEARN)
                begin
                    hit_next = 1'b1;
                    hit_idx_next = scan_idx;
                    hit_mac_next = head.mac;
                end
            end
            if (!old_ok_reg || head_age >= old_age_reg)
            begin
                old_ok_next = 1'b1;
                old_idx_next = scan_idx;
                old_age_next = head_age;
            end
        end
        else if (state_reg == ST_SCAN && !free_ok_reg)
        begin
            free_ok_next = 1'b1;
            free_idx_next = scan_idx;
        end

        if (state_reg == ST_WRITE)
        begin
            cmd.wr = hit_reg || free_ok_reg || old_ok_reg;
            cmd.wr_idx = hit_reg ? hit_idx_reg : (free_ok_reg ? free_idx_reg : old_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            now_reg   <= 8'd0;
            ov_reg    <= 1'b0;
            req_reg   <= REQ_TICK;
            bcast_hold_reg <= 1'b0;
            hit_reg <= 1'b0; free_ok_reg <= 1'b0; old_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            now_reg   <= now_next;
            hit_reg <= hit_next; free_ok_reg <= free_ok_next; old_ok_reg <= old_ok_next;
            // flag marks "tick pending": reused one-cycle pulse
            bcast_hold_reg <= accept && in_req == REQ_TICK;
            if (accept)
                req_reg <= in_req;
            if (m_axis_tvalid && m_axis_tready)
                ov_reg <= 1'b0;
            else if (accept && in_req == REQ_LOOKUP && in_bcast)
                ov_reg <= 1'b1;
            else if (state_reg == ST_OUT)
                ov_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        hit_mac_reg  <= hit_mac_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg  <= old_idx_next;
        old_age_reg  <= old_age_next;
        if (accept)
        begin
            ip_reg  <= (in_req == REQ_LOOKUP) ? in_hop : in_ip;
            mac_reg <= in_mac;
        end
        if (accept && in_req == REQ_LOOKUP && in_bcast)
            od_reg <= {6'd0, 32'd0, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1};
        else if (state_reg == ST_OUT)
            od_reg <= hit_reg ? {6'd0, 32'd0, 1'b0, hit_mac_reg, 1'b1}
                              : {6'd0, ip_reg, 1'b0, 48'd0, 1'b0};
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

endmodule

### design/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks for the ARP cache
// Watches handshakes and result encoding on the top-level ports.
// ----------------------------------------------------------------------------
module arpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a pending result blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open with result pending");

    // broadcast always reports found with all-ones mac
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[49] |->
            m_axis_tdata[0] && m_axis_tdata[48:1] == 48'hFFFF_FFFF_FFFF)
        else $error("bad broadcast result");

    // a miss carries no mac; a hit carries no request ip
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] ? m_axis_tdata[81:50] == 32'd0
                                           : m_axis_tdata[48:1] == 48'd0))
        else $error("inconsistent result fields");
endmodule

bind arp_cache_with_aging_unit arpc_checker u_arpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stream-level test of the ARP cache with aging
// Drives ticks, learns, lookups and reserved requests through s_axis with bursty timing,
// predicts each lookup result from a local model of the table and checks
// m_axis items in order. Configuration is rewritten between idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import arpc_pkg::*;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_req_t;

    typedef struct packed {
        logic        found;
        logic [47:0] mac;
        logic        bcast;
        logic [31:0] req_ip;
    } arp_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    always #1 clk = ~clk;

    arp_cache_with_aging_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Local copy of the table and registers
    logic [31:0] mdl_local, mdl_mask, mdl_router;
    logic [7:0]  mdl_max_age, mdl_now;
    logic [31:0] tbl_ip [ENTRIES];
    logic [47:0] tbl_mac [ENTRIES];
    logic [7:0]  tbl_stamp [ENTRIES];

    arp_req_t pending_reqs[$];
    arp_res_t expected_lookups[$];
    int       mismatches = 0;
    logic     driving_done = 1'b0;

    task automatic model_tick();
        mdl_now = mdl_now + 8'd1;
        for (int k = 0; k < ENTRIES; k++)
            if (tbl_ip[k] != 0 && 8'(mdl_now - tbl_stamp[k]) >= mdl_max_age)
                tbl_ip[k] = '0;
    endtask

    task automatic model_learn(logic [31:0] ip, logic [47:0] mac);
        int oldest;
        int unused;
        int k;
        oldest = -1;
        unused = -1;
        if (ip == 0) return;
        for (k = ENTRIES - 1; k >= 0; k--)
        begin
            if (tbl_ip[k] != 0)
            begin
                if (tbl_ip[k] == ip)
                begin
                    tbl_mac[k] = mac;
                    tbl_stamp[k] = mdl_now;
                    return;
                end
                if (oldest < 0 || 8'(mdl_now - tbl_stamp[oldest]) <
                    8'(mdl_now - tbl_stamp[k]))
                    oldest = k;
            end
            else
                unused = k;
        end
        k = (unused >= 0) ? unused : oldest;
        tbl_ip[k] = ip;
        tbl_mac[k] = mac;
        tbl_stamp[k] = mdl_now;
    endtask

    function automatic arp_res_t resolve_dest(logic [31:0] dst);
        arp_res_t r;
        logic [31:0] hop;
        r = '0;
        if (dst == 32'hFFFF_FFFF || dst == (mdl_local | ~mdl_mask))
        begin
            r.found = 1'b1;
            r.mac = '1;
            r.bcast = 1'b1;
            return r;
        end
        hop = ((dst & mdl_mask) != (mdl_local & mdl_mask)) ? mdl_router : dst;
        for (int k = 0; k < ENTRIES; k++)
            if (tbl_ip[k] != 0 && tbl_ip[k] == hop)
            begin
                r.found = 1'b1;
                r.mac = tbl_mac[k];
                return r;
            end
        r.req_ip = hop;
        return r;
    endfunction

    // Driver: bursts of items separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        arp_req_t nxt;
        if (s_axis_tvalid && s_axis_tready)
        begin
            nxt = pending_reqs.pop_front();
            case (nxt.req)
                REQ_TICK: model_tick();
                REQ_LEARN: model_learn(nxt.ip, nxt.mac);
                REQ_LOOKUP: expected_lookups.push_back(resolve_dest(nxt.ip));
                default: ;
            endcase
        end
        if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (rst_n && !driving_done && pending_reqs.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, pending_reqs[0].mac, pending_reqs[0].ip,
                                 pending_reqs[0].req};
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 25);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: receiver stalls in its own pattern and checks each result item
    int stall_mode = 0;
    always @(posedge clk)
    begin
        arp_res_t got;
        arp_res_t exp_r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[48:1], m_axis_tdata[49],
                   m_axis_tdata[81:50]};
            if (expected_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
            end
            else
            begin
                exp_r = expected_lookups.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"lookup mismatch: exp found=%b mac=%h bc=%b rip=%h",
                                  " got found=%b mac=%h bc=%b rip=%h"},
                                 exp_r.found, exp_r.mac, exp_r.bcast, exp_r.req_ip,
                                 got.found, got.mac, got.bcast, got.req_ip);
                end
            end
        end
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [31:0] pick_ip();
        // Draw half of the picks from a small on-subnet pool so learns and lookups collide
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return mdl_router;
            2: return 32'hFFFF_FFFF;
            3: return mdl_local | ~mdl_mask;
            4: return '0;
            default: return (mdl_local & mdl_mask) | 32'($urandom_range(0, 11));
        endcase
    endfunction

    function automatic arp_req_t rand_req();
        arp_req_t r;
        int sel;
        sel = $urandom_range(0, 99);
        r.req = (sel < 25) ? REQ_TICK : (sel < 60) ? REQ_LEARN :
                (sel < 97) ? REQ_LOOKUP : REQ_RESERVED;
        r.ip = pick_ip();
        r.mac = {$urandom(), $urandom()};
        return r;
    endfunction

    task automatic write_reg(logic [1:0] addr, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_LOCAL_IP: mdl_local = val;
            REG_SUBNET_MASK: mdl_mask = val;
            REG_ROUTER_IP: mdl_router = val;
            default: mdl_max_age = val[7:0];
        endcase
    endtask

    // Wait for queue drain, then allow a tick or learn to finish inside the block
    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_lookups.size() == 0);
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    task automatic push(logic [1:0] rq, logic [31:0] ip, logic [47:0] mac);
        pending_reqs.push_back('{rq, ip, mac});
    endtask

    initial
    begin
        mdl_local = '0;
        mdl_mask = 32'hFFFF_FF00;
        mdl_router = '0;
        mdl_max_age = 8'd20;
        mdl_now = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            tbl_ip[k] = '0;
            tbl_mac[k] = '0;
            tbl_stamp[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // Directed part under reset config: miss with zero hop, broadcasts
        push(REQ_LOOKUP, 32'h0, '0);
        push(REQ_LOOKUP, 32'hFFFF_FFFF, '1);
        push(REQ_LOOKUP, 32'h0000_00FF, '0);
        push(REQ_LEARN, 32'h0, 48'h1234);
        push(REQ_RESERVED, 32'h5, 48'h5);
        for (int k = 1; k <= ENTRIES + 1; k++)
            push(REQ_LEARN, 32'(k), 48'hFFFF_0000_0000 | 48'(k));
        push(REQ_LEARN, 32'h3, '1);
        push(REQ_LOOKUP, 32'h3, '0);
        push(REQ_LOOKUP, 32'h1, '0);
        push(REQ_LOOKUP, 32'h9, '0);
        push(REQ_LOOKUP, 32'h0A00_0001, '0);
        for (int k = 0; k < 21; k++) push(REQ_TICK, '0, '0);
        push(REQ_LOOKUP, 32'h9, '0);
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_LOCAL_IP, 32'hC0A8_0105);
                    write_reg(REG_SUBNET_MASK, 32'hFFFF_FF00);
                    write_reg(REG_ROUTER_IP, 32'hC0A8_0101);
                    write_reg(REG_MAX_AGE, 32'd1);
                end
                1: write_reg(REG_MAX_AGE, 32'd255);
                2:
                begin
                    write_reg(REG_SUBNET_MASK, 32'h0);
                    write_reg(REG_LOCAL_IP, 32'hFFFF_FFFF);
                    write_reg(REG_MAX_AGE, 32'd0);
                end
                3:
                begin
                    write_reg(REG_SUBNET_MASK, 32'hFFFF_FFFF);
                    write_reg(REG_LOCAL_IP, 32'h0A00_0002);
                    write_reg(REG_ROUTER_IP, 32'h0A00_0002);
                    write_reg(REG_MAX_AGE, 32'd4);
                end
                4:
                begin
                    write_reg(REG_SUBNET_MASK, 32'hFFFF_F000);
                    write_reg(REG_LOCAL_IP, $urandom());
                    write_reg(REG_ROUTER_IP, $urandom());
                    write_reg(REG_MAX_AGE, 32'($urandom_range(2, 40)));
                end
                default:
                begin
                    write_reg(REG_SUBNET_MASK, 32'hFFFF_FF00);
                    write_reg(REG_ROUTER_IP, (mdl_local & 32'hFFFF_FF00) | 32'd1);
                    write_reg(REG_MAX_AGE, 32'd12);
                end
            endcase
            for (int n = 0; n < 240; n++) pending_reqs.push_back(rand_req());
            drain();
        end
        driving_done = 1'b1;
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS arp_cache_with_aging_unit");
        else
            $display("FAIL arp_cache_with_aging_unit");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL arp_cache_with_aging_unit");
        $finish;
    end
endmodule
